// File: design/estm_pkg.sv
// ----------------------------------------------------------------------------
// estm_pkg
// Shared types, constants and fixed-point helpers for the Euler-angle,
// scale and translate matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package estm_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int TRIG_STEPS = 30;
    localparam int LAT        = TRIG_STEPS + 5;

    typedef logic signed [33:0] cw_t;
    typedef logic signed [31:0] trig_t;
    typedef logic signed [23:0] elem_t;

    localparam cw_t TRIG_GAIN = 34'sh026DD3B6A;
    localparam cw_t ROUND_30  = 34'sh020000000;

    typedef cw_t atan_tab_t [TRIG_STEPS];

    localparam atan_tab_t ATAN_TAB = '{
        34'sh020000000, 34'sh012E4051D, 34'sh009FB385B, 34'sh0051111D4, 34'sh0028B0D43,
        34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55, 34'sh00028BE53, 34'sh000145F2E,
        34'sh0000A2F98, 34'sh0000517CC, 34'sh000028BE6, 34'sh0000145F3, 34'sh000000A2F9,
        34'sh00000517C, 34'sh0000028BE, 34'sh00000145F, 34'sh000000A2F, 34'sh000000517,
        34'sh00000028B, 34'sh000000145, 34'sh0000000A2, 34'sh000000051, 34'sh000000028,
        34'sh000000014, 34'sh00000000A, 34'sh000000005, 34'sh000000002, 34'sh000000001
    };

    function automatic trig_t mul30(input trig_t a, input trig_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sh20000000;
        return p[61:30];
    endfunction

    function automatic elem_t scale_sat(input cw_t e, input elem_t s);
        logic signed [57:0] p;
        logic signed [27:0] r;
        elem_t              q;
        p = 58'(e) * 58'(s) + 58'sh20000000;
        r = p[57:30];
        if (r > 28'sh07FFFFF)
            q = 24'sh7FFFFF;
        else if (r < -28'sh0800000)
            q = 24'sh800000;
        else
            q = r[23:0];
        return q;
    endfunction

endpackage

`default_nettype wire

// File: design/euler_scale_translate_matrix_unit.sv
// ----------------------------------------------------------------------------
// euler_scale_translate_matrix_unit
// Streams Euler angles, scales and positions into the 3x4 model transform
// [Rx*Ry*Rz*diag(scale) | pos].
// ----------------------------------------------------------------------------
// One item is accepted per cycle and passes through 35 register stages: a
// prep stage, thirty pipelined CORDIC rotation stages (one per iteration, all
// three axes in parallel), a sign-fix stage, two product stages and a
// scale-and-saturate output register, which drives the result outputs. A
// stall on the output holds the whole pipeline; empty slots ahead of the
// output never block input.
`default_nettype none

module euler_scale_translate_matrix_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] angle_x,
    input  wire logic signed [15:0] angle_y,
    input  wire logic signed [15:0] angle_z,
    input  wire logic signed [23:0] scale_x,
    input  wire logic signed [23:0] scale_y,
    input  wire logic signed [23:0] scale_z,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [23:0]      c0_r0,
    output logic signed [23:0]      c0_r1,
    output logic signed [23:0]      c0_r2,
    output logic signed [23:0]      c1_r0,
    output logic signed [23:0]      c1_r1,
    output logic signed [23:0]      c1_r2,
    output logic signed [23:0]      c2_r0,
    output logic signed [23:0]      c2_r1,
    output logic signed [23:0]      c2_r2,
    output logic signed [31:0]      trans_x,
    output logic signed [31:0]      trans_y,
    output logic signed [31:0]      trans_z
);
    import estm_pkg::*;

    localparam int KT = TRIG_STEPS + 1;
    localparam int KM = TRIG_STEPS + 2;
    localparam int KE = TRIG_STEPS + 3;
    localparam int KO = TRIG_STEPS + 4;

    logic        adv;
    logic [LAT-1:0] v_reg;

    cw_t   x_reg   [TRIG_STEPS+1][3];
    cw_t   y_reg   [TRIG_STEPS+1][3];
    cw_t   z_reg   [TRIG_STEPS+1][3];
    logic  neg_reg [TRIG_STEPS+1][3];
    elem_t sc_reg  [KE+1][3];
    trig_t pos_reg [KO+1][3];

    trig_t s_reg [3];
    trig_t c_reg [3];

    trig_t cycz_reg, cxsz_reg, sxsy_reg, sxsz_reg, sycx_reg, szcy_reg;
    trig_t cxcz_reg, sxcz_reg, sysz_reg, sxcy_reg, cxcy_reg, sz_reg, cz_reg;
    trig_t cx_reg, sy_reg;

    cw_t   e_reg [9];
    elem_t o_reg [9];

    logic [15:0] ang_in [3];
    elem_t       sc_in  [3];
    trig_t       pos_in [3];
    logic [31:0] ph     [3];

    assign adv       = !v_reg[KO] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[KO];

    assign ang_in = '{angle_x, angle_y, angle_z};
    assign sc_in  = '{scale_x, scale_y, scale_z};
    assign pos_in = '{pos_x, pos_y, pos_z};

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            ph[a] = 32'(ang_in[a]) << (32 - ANGLE_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                x_reg[0][a]   <= TRIG_GAIN;
                y_reg[0][a]   <= '0;
                neg_reg[0][a] <= ph[a][31] ^ ph[a][30];
                z_reg[0][a]   <= 34'($signed({ph[a][30], ph[a][30:0]}));
                sc_reg[0][a]  <= sc_in[a];
                pos_reg[0][a] <= pos_in[a];
                for (int i = 0; i < TRIG_STEPS; i++)
                begin
                    if (!z_reg[i][a][33])
                    begin
                        x_reg[i+1][a] <= x_reg[i][a] - (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] + (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] - ATAN_TAB[i];
                    end
                    else
                    begin
                        x_reg[i+1][a] <= x_reg[i][a] + (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] - (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] + ATAN_TAB[i];
                    end
                    neg_reg[i+1][a] <= neg_reg[i][a];
                end
                for (int k = 0; k < KE; k++)
                begin
                    sc_reg[k+1][a] <= sc_reg[k][a];
                end
                for (int k = 0; k < KO; k++)
                begin
                    pos_reg[k+1][a] <= pos_reg[k][a];
                end
                c_reg[a] <= neg_reg[TRIG_STEPS][a] ? 32'(-x_reg[TRIG_STEPS][a])
                                                   : 32'(x_reg[TRIG_STEPS][a]);
                s_reg[a] <= neg_reg[TRIG_STEPS][a] ? 32'(-y_reg[TRIG_STEPS][a])
                                                   : 32'(y_reg[TRIG_STEPS][a]);
            end

            cycz_reg <= mul30(c_reg[1], c_reg[2]);
            cxsz_reg <= mul30(c_reg[0], s_reg[2]);
            sxsy_reg <= mul30(s_reg[0], s_reg[1]);
            sxsz_reg <= mul30(s_reg[0], s_reg[2]);
            sycx_reg <= mul30(s_reg[1], c_reg[0]);
            szcy_reg <= mul30(s_reg[2], c_reg[1]);
            cxcz_reg <= mul30(c_reg[0], c_reg[2]);
            sxcz_reg <= mul30(s_reg[0], c_reg[2]);
            sysz_reg <= mul30(s_reg[1], s_reg[2]);
            sxcy_reg <= mul30(s_reg[0], c_reg[1]);
            cxcy_reg <= mul30(c_reg[0], c_reg[1]);
            sz_reg   <= s_reg[2];
            cz_reg   <= c_reg[2];
            cx_reg   <= c_reg[0];
            sy_reg   <= s_reg[1];

            e_reg[0] <= 34'(cycz_reg);
            e_reg[1] <= 34'(cxsz_reg) + 34'(mul30(sxsy_reg, cz_reg));
            e_reg[2] <= 34'(sxsz_reg) - 34'(mul30(sycx_reg, cz_reg));
            e_reg[3] <= -34'(szcy_reg);
            e_reg[4] <= 34'(cxcz_reg) - 34'(mul30(sxsy_reg, sz_reg));
            e_reg[5] <= 34'(sxcz_reg) + 34'(mul30(sysz_reg, cx_reg));
            e_reg[6] <= 34'(sy_reg);
            e_reg[7] <= -34'(sxcy_reg);
            e_reg[8] <= 34'(cxcy_reg);

            for (int j = 0; j < 9; j++)
            begin
                o_reg[j] <= scale_sat(e_reg[j], sc_reg[KE][j / 3]);
            end
        end
    end

    assign c0_r0   = o_reg[0];
    assign c0_r1   = o_reg[1];
    assign c0_r2   = o_reg[2];
    assign c1_r0   = o_reg[3];
    assign c1_r1   = o_reg[4];
    assign c1_r2   = o_reg[5];
    assign c2_r0   = o_reg[6];
    assign c2_r1   = o_reg[7];
    assign c2_r2   = o_reg[8];
    assign trans_x = pos_reg[KO][0];
    assign trans_y = pos_reg[KO][1];
    assign trans_z = pos_reg[KO][2];

`ifndef NO_ASSERTIONS
    a_ready_follows_out : assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready does not follow output stall");

    a_stall_holds_pipe : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(v_reg))
        else $error("pipeline moved during stall");

    a_entry_advances : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted item lost at entry");

    a_trig_to_mul : assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[KT] && adv) |=> v_reg[KM])
        else $error("item lost between trig and product stages");
`endif

endmodule

`default_nettype wire

// File: sim/estm_checker.sv
// ----------------------------------------------------------------------------
// estm_checker
// Watches both item channels of the matrix unit, predicts each 3x4 transform
// from the accepted angles, scales and position with its own CORDIC and
// fixed-point arithmetic, and compares every result field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module estm_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic signed [15:0] angle_x,
    input  wire logic signed [15:0] angle_y,
    input  wire logic signed [15:0] angle_z,
    input  wire logic signed [23:0] scale_x,
    input  wire logic signed [23:0] scale_y,
    input  wire logic signed [23:0] scale_z,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [23:0] c0_r0,
    input  wire logic signed [23:0] c0_r1,
    input  wire logic signed [23:0] c0_r2,
    input  wire logic signed [23:0] c1_r0,
    input  wire logic signed [23:0] c1_r1,
    input  wire logic signed [23:0] c1_r2,
    input  wire logic signed [23:0] c2_r0,
    input  wire logic signed [23:0] c2_r1,
    input  wire logic signed [23:0] c2_r2,
    input  wire logic signed [31:0] trans_x,
    input  wire logic signed [31:0] trans_y,
    input  wire logic signed [31:0] trans_z,
    output int                      fail_count,
    output int                      pending_count
);
    import estm_pkg::*;

    typedef struct packed {
        logic signed [23:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
        logic signed [31:0] tx, ty, tz;
    } transform_t;

    localparam longint ARCTAN [30] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
    };

    transform_t transforms_due [$];
    int         mismatches;

    function automatic longint round_q30(longint a, longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function automatic void rotate_angle(logic [15:0] ang, output longint s,
                                         output longint c);
        logic [31:0] ph;
        logic        flip;
        longint      x, y, z, dx, dy;
        ph   = {ang[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
        flip = ph[31] ^ ph[30];
        if (flip)
            ph = ph - 32'h80000000;
        z = longint'($signed(ph));
        x = 64'h26DD3B6A;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - ARCTAN[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + ARCTAN[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [23:0] scale_clamp(longint e, logic signed [23:0] k);
        longint r;
        r = round_q30(e, longint'(k));
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        return r[23:0];
    endfunction

    function automatic transform_t model_transform();
        longint sx, cx, sy, cy, sz, cz, sxsy;
        transform_t t;
        rotate_angle(angle_x, sx, cx);
        rotate_angle(angle_y, sy, cy);
        rotate_angle(angle_z, sz, cz);
        sxsy  = round_q30(sx, sy);
        t.m00 = scale_clamp(round_q30(cy, cz), scale_x);
        t.m01 = scale_clamp(round_q30(cx, sz) + round_q30(sxsy, cz), scale_x);
        t.m02 = scale_clamp(round_q30(sx, sz) - round_q30(round_q30(sy, cx), cz), scale_x);
        t.m10 = scale_clamp(-round_q30(sz, cy), scale_y);
        t.m11 = scale_clamp(round_q30(cx, cz) - round_q30(sxsy, sz), scale_y);
        t.m12 = scale_clamp(round_q30(sx, cz) + round_q30(round_q30(sy, sz), cx), scale_y);
        t.m20 = scale_clamp(sy, scale_z);
        t.m21 = scale_clamp(-round_q30(sx, cy), scale_z);
        t.m22 = scale_clamp(round_q30(cx, cy), scale_z);
        t.tx  = pos_x;
        t.ty  = pos_y;
        t.tz  = pos_z;
        return t;
    endfunction

    assign fail_count = mismatches;

    always @(posedge clk or negedge rst_n)
    begin
        transform_t got, want;
        if (!rst_n)
        begin
            mismatches = 0;
            transforms_due.delete();
            pending_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2,
                        trans_x, trans_y, trans_z};
                if (transforms_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: %h", got);
                end
                else
                begin
                    want = transforms_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            if (in_valid && in_ready)
                transforms_due = {transforms_due, model_transform()};
            pending_count = transforms_due.size();
        end
    end
endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives directed and random Euler angle, scale and position items into the
// matrix unit with random gaps and output stalls; the checker does the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import estm_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic in_ready, out_valid;
    logic signed [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
    logic signed [23:0] scale_x = '0, scale_y = '0, scale_z = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [23:0] c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2;
    logic signed [31:0] trans_x, trans_y, trans_z;
    int fail_count, pending_count;
    int cycle_count = 0;
    bit calm_phase = 1'b0;

    always #2 clk = ~clk;

    euler_scale_translate_matrix_unit dut (.*);
    estm_checker u_checker (.*);

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return {2'($urandom_range(0, 3)), 14'h0};
            3: return 16'($urandom_range(0, 3) * 16'h4000 + $urandom_range(0, 8) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_scale();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed(24'h010000) * ($urandom_range(0, 1) ? 1 : -1));
            3: return 24'($signed(20'($urandom)));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [15:0] ax, ay, az, logic [23:0] kx, ky, kz,
                             logic [31:0] px, py, pz);
        int idle;
        idle = $urandom_range(0, 4);
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        angle_x <= ax; angle_y <= ay; angle_z <= az;
        scale_x <= kx; scale_y <= ky; scale_z <= kz;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        int hold;
        if (calm_phase)
            out_ready <= 1'b1;
        else
        begin
            hold = $urandom_range(0, 4);
            out_ready <= (hold == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] corner_angle [6];
        corner_angle = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h2000};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 6; i++)
            send_item(corner_angle[i], corner_angle[(i + 2) % 6], corner_angle[(i + 4) % 6],
                      24'h010000, 24'h7FFFFF, 24'h800000,
                      32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        send_item(16'hFFFF, 16'h0001, 16'h1555, 24'h800000, 24'h7FFFFF, 24'hFF0000,
                  32'h0, 32'h00010000, 32'hFFFF0000);
        send_item(16'h0000, 16'h0000, 16'h0000, 24'h0, 24'h0, 24'h0, 32'h0, 32'h0, 32'h0);
        send_item(16'h6000, 16'hA000, 16'h3000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                  32'h55555555, 32'hAAAAAAAA, 32'h12345678);
        send_item(16'h9000, 16'h5000, 16'hE000, 24'h800000, 24'h800000, 24'h800000,
                  32'hAAAAAAAA, 32'h55555555, 32'h87654321);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        @(negedge clk);
        for (int n = 0; n < 1040; n++)
        begin
            if (n == 300)
            begin
                in_valid <= 1'b0;
                while (pending_count != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            calm_phase = (n >= 600 && n < 700);
            send_item(pick_angle(), pick_angle(), pick_angle(),
                      pick_scale(), pick_scale(), pick_scale(),
                      $urandom, $urandom, $urandom);
        end
        in_valid <= 1'b0;
        calm_phase = 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

`default_nettype wire
